// ----- rtl/core/tswr_pkg.sv -----
package tswr_pkg;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_ACK  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [1:0] KIND_NEW    = 2'd0;
    localparam logic [1:0] KIND_RETX   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] REG_ISN  = 2'd0;
    localparam logic [1:0] REG_IRTO = 2'd1;
    localparam logic [1:0] REG_MAXP = 2'd2;

    localparam logic [5:0]  MAX_OUT       = 6'd32;
    localparam logic [19:0] IRTO_RESET    = 20'd1000;
    localparam logic [9:0]  MAXP_RESET    = 10'd1000;
    localparam logic [31:0] HALF_SPACE    = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [23:0] bytes_available;
        logic        stream_finished;
        logic        stream_error;
        logic [31:0] ackno;
        logic        ackno_valid;
        logic [15:0] adv_window;
        logic        peer_reset;
        logic [31:0] elapsed_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] seqno;
        logic        syn_flag;
        logic        fin_flag;
        logic        rst_flag;
        logic [9:0]  payload_len;
        logic [15:0] in_flight;
        logic [7:0]  retx_count;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_ACK,
        OP_TICK,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op      op;
        t_in_item item;
    } t_req;

    typedef struct packed {
        logic vld;
        t_req req;
    } t_fq;

    typedef struct packed {
        logic [63:0] abs_seq;
        logic [9:0]  payload;
        logic        syn;
        logic        fin;
        logic        rst;
    } t_seg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_ACK_A,
        ST_ACK_B,
        ST_ACK_RD,
        ST_ACK_CHK,
        ST_ACK_END,
        ST_TICK_A,
        ST_TICK_B,
        ST_TICK_EMIT,
        ST_STATUS
    } t_state;

endpackage

// ----- rtl/core/tswr_if.sv -----
interface tswr_req_if import tswr_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface tswr_res_if import tswr_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/core/tswr_ram.sv -----
module tswr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/tswr_front.sv -----
module tswr_front import tswr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tswr_req_if.sink   i_req,
    output t_fq        o_fq,
    input  logic       i_pop
);
    t_req       r_buf [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_cnt, n_cnt;
    logic       push;
    t_req       cls;

    // Decode the command once here so the back end only sees operations.
    always_comb begin
        cls.item = i_req.data;
        case (i_req.data.cmd)
            CMD_PUSH: cls.op = OP_PUSH;
            CMD_ACK:  cls.op = OP_ACK;
            CMD_TICK: cls.op = OP_TICK;
            default:  cls.op = OP_NONE;
        endcase
    end

    assign i_req.ready = (r_cnt != 2'd2);
    assign push        = i_req.valid && i_req.ready;
    assign o_fq.vld    = (r_cnt != 2'd0);
    assign o_fq.req    = r_buf[r_rptr];

    always_comb begin
        n_wptr = push ? ~r_wptr : r_wptr;
        n_rptr = (i_pop && o_fq.vld) ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt + {1'b0, push} - {1'b0, i_pop && o_fq.vld};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
        if (push) begin
            r_buf[r_wptr] <= cls;
        end
    end
endmodule

// ----- rtl/core/tswr_back.sv -----
module tswr_back import tswr_pkg::*; #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  t_fq         i_fq,
    output logic        o_pop,
    tswr_res_if.source  o_res
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [FW-1:0] FULL = FW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

    t_state      r_state, n_state;
    t_req        r_req, n_req;
    logic [31:0] r_isn, n_isn;
    logic [19:0] r_irto, n_irto;
    logic [9:0]  r_maxp, n_maxp;
    logic [63:0] r_next, n_next;
    logic [63:0] r_acked, n_acked;
    logic [16:0] r_outst, n_outst;
    logic [15:0] r_win, n_win;
    logic        r_syn_done, n_syn_done;
    logic        r_fin_done, n_fin_done;
    logic        r_err, n_err;
    logic        r_ton, n_ton;
    logic [31:0] r_tcnt, n_tcnt;
    logic [31:0] r_rto, n_rto;
    logic [7:0]  r_retx, n_retx;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [FW-1:0] r_fill, n_fill;
    logic [16:0] r_infl, n_infl;
    logic [23:0] r_rem, n_rem;
    logic [5:0]  r_n, n_n;
    logic [63:0] r_a, n_a;
    logic        r_fresh, n_fresh;
    logic        r_ovld, n_ovld;
    t_out_item   r_odata, n_odata;

    logic        ram_we, ram_re;
    t_seg        ram_wdata, ram_rdata;
    logic        can_emit;

    // Segment cutting for the current push step.
    logic [16:0] eff, space, pl0, infl_n;
    logic [9:0]  pl1, pl;
    logic [23:0] rem_n;
    logic        seg_syn, seg_fin, cond, more;
    logic [10:0] seg_len;
    logic [FW-1:0] fill_n;
    logic [5:0]  cnt_n;

    // Ack unwrapping against the next sequence number.
    logic [31:0] off, nlo, nhi, d_up, d_dn;
    logic [63:0] cand;
    logic [32:0] tsum;
    logic [63:0] head_end;
    logic [10:0] head_len;

    tswr_ram #(.WIDTH($bits(t_seg)), .DEPTH(QUEUE_DEPTH)) u_segq (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    assign can_emit    = !r_ovld || o_res.ready;
    assign o_res.valid = r_ovld;
    assign o_res.data  = r_odata;

    always_comb begin
        eff     = (r_win == 16'd0) ? 17'd1 : {1'b0, r_win};
        cond    = (r_infl < eff) && (r_fill < FULL) && (r_n < MAX_OUT);
        space   = eff - r_infl;
        seg_syn = !r_syn_done;
        pl0     = space - {16'd0, seg_syn};
        pl1     = (pl0 > {7'd0, r_maxp}) ? r_maxp : pl0[9:0];
        pl      = ({14'd0, pl1} > r_rem) ? r_rem[9:0] : pl1;
        rem_n   = r_rem - {14'd0, pl};
        seg_fin = !r_fin_done && r_req.item.stream_finished && (rem_n == 24'd0)
                  && ({7'd0, pl} + {16'd0, seg_syn} < space);
        seg_len = {1'b0, pl} + {10'd0, seg_syn} + {10'd0, seg_fin};
        infl_n  = r_infl + {6'd0, seg_len};
        fill_n  = r_fill + FW'(1);
        cnt_n   = r_n + 6'd1;
        // Another segment follows only if it would carry payload or a FIN.
        more    = !seg_fin && (infl_n < eff) && (fill_n < FULL) && (cnt_n < MAX_OUT)
                  && (((r_maxp != 10'd0) && (rem_n != 24'd0))
                      || (!r_fin_done && r_req.item.stream_finished
                          && (rem_n == 24'd0)));

        ram_wdata.abs_seq = r_next;
        ram_wdata.payload = pl;
        ram_wdata.syn     = seg_syn;
        ram_wdata.fin     = seg_fin;
        ram_wdata.rst     = r_err || r_req.item.stream_error;

        off  = r_req.item.ackno - r_isn;
        nlo  = r_next[31:0];
        nhi  = r_next[63:32];
        d_up = off - nlo;
        d_dn = nlo - off;
        if ((off > nlo) && (d_up > HALF_SPACE) && (nhi != 32'd0)) begin
            cand = {nhi - 32'd1, off};
        end else if ((off < nlo) && (d_dn > HALF_SPACE)) begin
            cand = {nhi + 32'd1, off};
        end else begin
            cand = {nhi, off};
        end

        tsum     = {1'b0, r_tcnt} + {1'b0, r_req.item.elapsed_ms};
        head_len = {1'b0, ram_rdata.payload} + {10'd0, ram_rdata.syn}
                   + {10'd0, ram_rdata.fin};
        head_end = ram_rdata.abs_seq + {53'd0, head_len};
    end

    always_comb begin
        n_state = r_state;  n_req = r_req;  n_isn = r_isn;  n_irto = r_irto;
        n_maxp = r_maxp;  n_next = r_next;  n_acked = r_acked;  n_outst = r_outst;
        n_win = r_win;  n_syn_done = r_syn_done;  n_fin_done = r_fin_done;
        n_err = r_err;  n_ton = r_ton;  n_tcnt = r_tcnt;  n_rto = r_rto;
        n_retx = r_retx;  n_head = r_head;  n_tail = r_tail;  n_fill = r_fill;
        n_infl = r_infl;  n_rem = r_rem;  n_n = r_n;  n_a = r_a;  n_fresh = r_fresh;
        n_ovld = r_ovld && !o_res.ready;
        n_odata = r_odata;
        o_pop = 1'b0;
        ram_we = 1'b0;
        ram_re = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ISN:  n_isn = i_cfg_data;
                REG_IRTO: n_irto = i_cfg_data[19:0];
                REG_MAXP: n_maxp = i_cfg_data[9:0];
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (i_fq.vld) begin
                    o_pop  = 1'b1;
                    n_req  = i_fq.req;
                    n_infl = r_next[16:0] - r_acked[16:0];
                    n_rem  = i_fq.req.item.bytes_available;
                    n_n    = 6'd0;
                    case (i_fq.req.op)
                        OP_PUSH: n_state = ST_PUSH;
                        OP_ACK:  n_state = ST_ACK_A;
                        OP_TICK: n_state = ST_TICK_A;
                        default: n_state = ST_STATUS;
                    endcase
                end
            end
            ST_PUSH: begin
                if (!cond || (seg_len == 11'd0)) begin
                    n_state = ST_STATUS;
                end else if (can_emit) begin
                    ram_we     = 1'b1;
                    n_tail     = (r_tail == LAST_IDX) ? '0 : r_tail + AW'(1);
                    n_fill     = fill_n;
                    n_outst    = r_outst + {6'd0, seg_len};
                    n_next     = r_next + {53'd0, seg_len};
                    n_infl     = infl_n;
                    n_rem      = rem_n;
                    n_n        = cnt_n;
                    n_syn_done = 1'b1;
                    n_fin_done = r_fin_done || seg_fin;
                    if (!r_ton) begin
                        n_ton  = 1'b1;
                        n_tcnt = 32'd0;
                    end
                    n_ovld              = 1'b1;
                    n_odata.kind        = KIND_NEW;
                    n_odata.seqno       = r_next[31:0] + r_isn;
                    n_odata.syn_flag    = seg_syn;
                    n_odata.fin_flag    = seg_fin;
                    n_odata.rst_flag    = ram_wdata.rst;
                    n_odata.payload_len = pl;
                    n_odata.in_flight   = n_outst[15:0];
                    n_odata.retx_count  = r_retx;
                    n_odata.last        = !more;
                    if (!more) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_ACK_A: begin
                if (r_req.item.peer_reset) begin
                    n_err   = 1'b1;
                    n_state = ST_STATUS;
                end else begin
                    n_win = r_req.item.adv_window;
                    n_a   = cand;
                    n_state = r_req.item.ackno_valid ? ST_ACK_B : ST_STATUS;
                end
            end
            ST_ACK_B: begin
                if (r_a > r_next) begin
                    n_state = ST_STATUS;
                end else begin
                    n_fresh = (r_a > r_acked);
                    if (r_a > r_acked) begin
                        n_acked = r_a;
                    end
                    n_state = ST_ACK_RD;
                end
            end
            ST_ACK_RD: begin
                if (r_fill == '0) begin
                    n_state = ST_ACK_END;
                end else begin
                    ram_re  = 1'b1;
                    n_state = ST_ACK_CHK;
                end
            end
            ST_ACK_CHK: begin
                if (head_end > r_acked) begin
                    n_state = ST_ACK_END;
                end else begin
                    n_outst = r_outst - {6'd0, head_len};
                    n_head  = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
                    n_fill  = r_fill - FW'(1);
                    n_state = ST_ACK_RD;
                end
            end
            ST_ACK_END: begin
                if (r_fresh) begin
                    n_rto  = {12'd0, r_irto};
                    n_retx = 8'd0;
                    n_ton  = (r_fill != '0);
                    if (r_fill != '0) begin
                        n_tcnt = 32'd0;
                    end
                end
                n_state = ST_STATUS;
            end
            ST_TICK_A: begin
                n_tcnt  = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
                n_state = ST_TICK_B;
            end
            ST_TICK_B: begin
                if (r_ton && (r_tcnt >= r_rto) && (r_fill != '0)) begin
                    ram_re  = 1'b1;
                    n_state = ST_TICK_EMIT;
                end else begin
                    n_state = ST_STATUS;
                end
            end
            ST_TICK_EMIT: begin
                if (can_emit) begin
                    if (r_win != 16'd0) begin
                        if (r_retx != 8'hFF) begin
                            n_retx = r_retx + 8'd1;
                        end
                        n_rto = r_rto[31] ? 32'hFFFF_FFFF : {r_rto[30:0], 1'b0};
                    end
                    n_tcnt              = 32'd0;
                    n_ton               = 1'b1;
                    n_ovld              = 1'b1;
                    n_odata.kind        = KIND_RETX;
                    n_odata.seqno       = ram_rdata.abs_seq[31:0] + r_isn;
                    n_odata.syn_flag    = ram_rdata.syn;
                    n_odata.fin_flag    = ram_rdata.fin;
                    n_odata.rst_flag    = ram_rdata.rst;
                    n_odata.payload_len = ram_rdata.payload;
                    n_odata.in_flight   = r_outst[15:0];
                    n_odata.retx_count  = n_retx;
                    n_odata.last        = 1'b1;
                    n_state             = ST_IDLE;
                end
            end
            ST_STATUS: begin
                if (can_emit) begin
                    n_ovld              = 1'b1;
                    n_odata.kind        = KIND_STATUS;
                    n_odata.seqno       = r_next[31:0] + r_isn;
                    n_odata.syn_flag    = 1'b0;
                    n_odata.fin_flag    = 1'b0;
                    n_odata.rst_flag    = r_err || r_req.item.stream_error;
                    n_odata.payload_len = 10'd0;
                    n_odata.in_flight   = r_outst[15:0];
                    n_odata.retx_count  = r_retx;
                    n_odata.last        = 1'b1;
                    n_state             = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_isn      <= 32'd0;
            r_irto     <= IRTO_RESET;
            r_maxp     <= MAXP_RESET;
            r_next     <= 64'd0;
            r_acked    <= 64'd0;
            r_outst    <= 17'd0;
            r_win      <= 16'd1;
            r_syn_done <= 1'b0;
            r_fin_done <= 1'b0;
            r_err      <= 1'b0;
            r_ton      <= 1'b0;
            r_tcnt     <= 32'd0;
            r_rto      <= {12'd0, IRTO_RESET};
            r_retx     <= 8'd0;
            r_head     <= '0;
            r_tail     <= '0;
            r_fill     <= '0;
            r_ovld     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_isn      <= n_isn;
            r_irto     <= n_irto;
            r_maxp     <= n_maxp;
            r_next     <= n_next;
            r_acked    <= n_acked;
            r_outst    <= n_outst;
            r_win      <= n_win;
            r_syn_done <= n_syn_done;
            r_fin_done <= n_fin_done;
            r_err      <= n_err;
            r_ton      <= n_ton;
            r_tcnt     <= n_tcnt;
            r_rto      <= n_rto;
            r_retx     <= n_retx;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_fill     <= n_fill;
            r_ovld     <= n_ovld;
        end
        r_req   <= n_req;
        r_infl  <= n_infl;
        r_rem   <= n_rem;
        r_n     <= n_n;
        r_a     <= n_a;
        r_fresh <= n_fresh;
        r_odata <= n_odata;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL) else $error("segment queue overfilled");
    a_ack_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acked <= r_next) else $error("acknowledged point passed next sequence");
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> (r_head == r_tail)) else $error("empty queue with split pointers");
    a_empty_outst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> (r_outst == 17'd0)) else $error("outstanding count without segments");
`endif
endmodule

// ----- rtl/core/tcp_sender_window_retransmit_top.sv -----
// TCP sender control with a sliding window and retransmission timeout backoff.
// Requests are taken into a two-entry queue and run one at a time by a back-end
// sequencer that owns the window state and the retransmit segment queue (a RAM
// of QUEUE_DEPTH headers with one write and one registered read port). A push
// emits one segment per step until the window, queue or stream is used up; an
// ack first handles a peer reset and the window, then checks the ackno against
// the sent data, then reads and checks each queue head in turn, retiring the
// acknowledged ones; a tick adds the elapsed time, then checks the timer and may
// emit one retransmission; anything else returns a status. A step that emits
// stalls while a result waits on the output. Every request returns one or more
// results, the final one marked last. Results sit in an output register, so the
// back end keeps working while the front still accepts requests. Configuration
// must be written by the user only while idle; the block does not enforce it.
module tcp_sender_window_retransmit_top import tswr_pkg::*; #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    tswr_req_if.sink    i_req,
    tswr_res_if.source  o_res
);
    t_fq  fq;
    logic pop;

    tswr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_fq    (fq),
        .i_pop   (pop)
    );

    tswr_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fq       (fq),
        .o_pop      (pop),
        .o_res      (o_res)
    );
endmodule

// ----- tb/tb_tcp_sender_window_retransmit_top.sv -----
`timescale 1ns / 1ps

module tb_tcp_sender_window_retransmit_top import tswr_pkg::*;;

    localparam logic [1:0] CMD_IDLE = 2'd3;
    localparam int SEG_SLOTS = 32;
    localparam int DRAIN_CYCLES = 80;
    localparam int LONG_HOLD = 400;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_PER_PHASE = 113;

    typedef struct {
        longint unsigned abs_seq;
        int unsigned     len;
        int unsigned     payload;
        bit              syn;
        bit              fin;
        bit              rst;
    } t_seg_rec;

    typedef struct {
        t_in_item  item;
        bit        ack_to_next;
        bit        has_typed;
        t_out_item typed;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [31:0] i_cfg_data;

    tswr_req_if req_if ();
    tswr_res_if res_if ();

    tcp_sender_window_retransmit_top dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_req     (req_if),
        .o_res     (res_if)
    );

    // Sender model state and configuration.
    logic [31:0] isn_reg;
    logic [19:0] irto_reg;
    logic [9:0]  maxp_reg;
    longint unsigned next_seq, acked_seq;
    int unsigned outstanding;
    logic [15:0] peer_win;
    bit syn_sent, fin_sent, errored, timer_running;
    logic [31:0] timer_ms, rto_ms;
    logic [7:0] retx_cnt;
    t_seg_rec retx_store [SEG_SLOTS];
    int unsigned store_head, store_tail, store_fill;

    t_out_item seg_results [$];
    t_out_item pending_results [$];
    t_stim_row directed_rows [$];

    int mismatches;
    int cycles;
    bit hold_request;
    bit no_idle;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] wrap_abs(longint unsigned a);
        return 32'(a + 64'(isn_reg));
    endfunction

    function automatic longint unsigned unwrap_ack(logic [31:0] n, longint unsigned cp);
        longint unsigned off;
        longint unsigned cand;
        off = 64'(32'(n - isn_reg));
        cand = (cp & 64'hFFFF_FFFF_0000_0000) + off;
        if (cand > cp && cand - cp > 64'h8000_0000 && cand >= 64'h1_0000_0000)
            cand -= 64'h1_0000_0000;
        else if (cand < cp && cp - cand > 64'h8000_0000)
            cand += 64'h1_0000_0000;
        return cand;
    endfunction

    function automatic t_out_item make_result(logic [1:0] kind, logic [31:0] seq, bit syn,
                                              bit fin, bit rst, logic [9:0] plen,
                                              logic [15:0] infl, logic [7:0] retx);
        t_out_item r;
        r.kind = kind;
        r.seqno = seq;
        r.syn_flag = syn;
        r.fin_flag = fin;
        r.rst_flag = rst;
        r.payload_len = plen;
        r.in_flight = infl;
        r.retx_count = retx;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic t_in_item make_item(logic [1:0] cmd, logic [23:0] avail, bit fin,
                                           bit serr, logic [31:0] ackno, bit av,
                                           logic [15:0] win, bit prst, logic [31:0] el);
        t_in_item it;
        it.cmd = cmd;
        it.bytes_available = avail;
        it.stream_finished = fin;
        it.stream_error = serr;
        it.ackno = ackno;
        it.ackno_valid = av;
        it.adv_window = win;
        it.peer_reset = prst;
        it.elapsed_ms = el;
        return it;
    endfunction

    task automatic sender_reset();
        isn_reg = 32'd0;
        irto_reg = IRTO_RESET;
        maxp_reg = MAXP_RESET;
        next_seq = 0;
        acked_seq = 0;
        outstanding = 0;
        peer_win = 16'd1;
        syn_sent = 0;
        fin_sent = 0;
        errored = 0;
        timer_running = 0;
        timer_ms = 0;
        rto_ms = 32'(IRTO_RESET);
        retx_cnt = 0;
        store_head = 0;
        store_tail = 0;
        store_fill = 0;
    endtask

    // Fills seg_results with what the block answers to one request.
    task automatic compute_segments(t_in_item it);
        longint unsigned eff, infl, remaining, space, plen, acked;
        longint unsigned tsum;
        bit rst, fresh;
        t_seg_rec s;
        t_seg_rec h;
        int n;
        seg_results.delete();
        n = 0;
        rst = errored || it.stream_error;
        if (it.cmd == CMD_PUSH) begin
            eff = (peer_win != 0) ? 64'(peer_win) : 64'd1;
            infl = next_seq - acked_seq;
            remaining = 64'(it.bytes_available);
            while (infl < eff && store_fill < SEG_SLOTS && n < int'(MAX_OUT)) begin
                space = eff - infl;
                s.abs_seq = next_seq;
                s.rst = rst;
                s.syn = !syn_sent;
                s.fin = 0;
                if (s.syn)
                    syn_sent = 1;
                plen = space - (s.syn ? 1 : 0);
                if (plen > 64'(maxp_reg))
                    plen = 64'(maxp_reg);
                if (plen > remaining)
                    plen = remaining;
                remaining -= plen;
                if (!fin_sent && it.stream_finished && remaining == 0 &&
                    (s.syn ? 1 : 0) + plen < space) begin
                    s.fin = 1;
                    fin_sent = 1;
                end
                s.payload = 32'(plen);
                s.len = 32'(plen) + (s.syn ? 1 : 0) + (s.fin ? 1 : 0);
                if (s.len == 0)
                    break;
                retx_store[store_tail] = s;
                store_tail = (store_tail + 1) % SEG_SLOTS;
                store_fill++;
                outstanding += s.len;
                next_seq += s.len;
                infl += s.len;
                if (!timer_running) begin
                    timer_running = 1;
                    timer_ms = 0;
                end
                seg_results.push_back(make_result(KIND_NEW, wrap_abs(s.abs_seq), s.syn, s.fin,
                                                  s.rst, 10'(s.payload), 16'(outstanding),
                                                  retx_cnt));
                n++;
                if (s.fin)
                    break;
            end
        end else if (it.cmd == CMD_ACK) begin
            if (it.peer_reset) begin
                errored = 1;
            end else begin
                peer_win = it.adv_window;
                if (it.ackno_valid) begin
                    acked = unwrap_ack(it.ackno, next_seq);
                    if (acked <= next_seq) begin
                        fresh = acked > acked_seq;
                        if (fresh)
                            acked_seq = acked;
                        while (store_fill > 0) begin
                            h = retx_store[store_head];
                            if (h.abs_seq + h.len > acked_seq)
                                break;
                            outstanding -= h.len;
                            store_head = (store_head + 1) % SEG_SLOTS;
                            store_fill--;
                        end
                        if (fresh) begin
                            rto_ms = 32'(irto_reg);
                            retx_cnt = 0;
                            if (store_fill > 0) begin
                                timer_running = 1;
                                timer_ms = 0;
                            end else begin
                                timer_running = 0;
                            end
                        end
                    end
                end
            end
        end else if (it.cmd == CMD_TICK) begin
            tsum = 64'(timer_ms) + 64'(it.elapsed_ms);
            timer_ms = (tsum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(tsum);
            if (timer_running && timer_ms >= rto_ms && store_fill > 0) begin
                h = retx_store[store_head];
                if (peer_win > 0) begin
                    if (retx_cnt < 8'd255)
                        retx_cnt++;
                    rto_ms = (rto_ms > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : rto_ms * 2;
                end
                timer_ms = 0;
                seg_results.push_back(make_result(KIND_RETX, wrap_abs(h.abs_seq), h.syn, h.fin,
                                                  h.rst, 10'(h.payload), 16'(outstanding),
                                                  retx_cnt));
            end
        end
        if (seg_results.size() == 0)
            seg_results.push_back(make_result(KIND_STATUS, wrap_abs(next_seq), 0, 0,
                                              errored || it.stream_error, 10'd0,
                                              16'(outstanding), retx_cnt));
        seg_results[seg_results.size() - 1].last = 1'b1;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        case (idx)
            REG_ISN:  isn_reg = val;
            REG_IRTO: irto_reg = val[19:0];
            REG_MAXP: maxp_reg = val[9:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Offers one request; typed expectations replace the model's where given.
    task automatic send_request(t_in_item it, bit has_typed, t_out_item typed);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            @(negedge i_clk);
            req_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        req_if.valid = 1'b1;
        req_if.data = it;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        compute_segments(it);
        if (has_typed) begin
            typed.last = 1'b1;
            pending_results.push_back(typed);
        end else begin
            foreach (seg_results[k]) pending_results.push_back(seg_results[k]);
        end
    endtask

    function automatic t_in_item random_request(bit allow_prst);
        t_in_item it;
        int unsigned pick, k;
        longint unsigned target;
        it = make_item(CMD_PUSH, 24'($urandom), $urandom_range(0, 7) == 0,
                       $urandom_range(0, 9) == 0, $urandom, $urandom_range(0, 9) != 0,
                       16'($urandom), 0, $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            it.cmd = CMD_PUSH;
            if ($urandom_range(0, 9) != 0)
                it.bytes_available = 24'($urandom_range(0, 3000));
        end else if (pick < 72) begin
            it.cmd = CMD_ACK;
            k = $urandom_range(0, 99);
            if (store_fill > 0 && k < 65) begin
                // Acknowledge exactly up to the end of some queued segment.
                k = $urandom_range(0, store_fill - 1);
                target = retx_store[(store_head + k) % SEG_SLOTS].abs_seq +
                         retx_store[(store_head + k) % SEG_SLOTS].len;
                it.ackno = wrap_abs(target);
            end else if (k < 75) begin
                it.ackno = wrap_abs(acked_seq + $urandom_range(0, 32'(next_seq - acked_seq)));
            end else if (k < 82) begin
                it.ackno = wrap_abs(next_seq + $urandom_range(1, 2000));
            end else if (k < 89) begin
                it.ackno = wrap_abs(acked_seq - $urandom_range(1, 2000));
            end
            k = $urandom_range(0, 99);
            if (k < 12)
                it.adv_window = 16'd0;
            else if (k < 35)
                it.adv_window = 16'($urandom_range(1, 50));
            it.peer_reset = allow_prst && $urandom_range(0, 1);
        end else if (pick < 96) begin
            it.cmd = CMD_TICK;
            k = $urandom_range(0, 99);
            if (k < 45)
                it.elapsed_ms = $urandom_range(0, rto_ms > 5000 ? 5000 : rto_ms);
            else if (k < 85)
                it.elapsed_ms = rto_ms;
        end else begin
            it.cmd = (pick < 98) ? CMD_IDLE : CMD_ACK;
        end
        return it;
    endfunction

    // Result side: random stalls per result, plus one long hold-off on request.
    initial begin
        int gap;
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                res_if.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_request = 0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                res_if.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_if.ready = 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: got %p", res_if.data);
            end else begin
                want = pending_results.pop_front();
                if (res_if.data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result mismatch: expected %p, got %p", want, res_if.data);
                end
            end
        end
    end

    initial begin
        t_out_item none;
        t_stim_row row;
        int drain_guard;
        none = '0;
        mismatches = 0;
        cycles = 0;
        hold_request = 0;
        no_idle = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_ISN;
        i_cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        sender_reset();

        // Directed rows. Typed values are those obvious straight after reset.
        row.ack_to_next = 0;
        row.has_typed = 1;
        row.item = make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
        row.typed = make_result(KIND_STATUS, 0, 0, 0, 0, 0, 0, 0);
        directed_rows.push_back(row);
        row.item = make_item(CMD_IDLE, 0, 0, 0, 0, 0, 0, 0, 0);
        directed_rows.push_back(row);
        row.item = make_item(CMD_PUSH, 0, 0, 0, 0, 0, 0, 0, 0);
        row.typed = make_result(KIND_NEW, 0, 1, 0, 0, 0, 1, 0);
        directed_rows.push_back(row);
        row.item = make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 999);
        row.typed = make_result(KIND_STATUS, 1, 0, 0, 0, 0, 1, 0);
        directed_rows.push_back(row);
        row.item = make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 1);
        row.typed = make_result(KIND_RETX, 0, 1, 0, 0, 0, 1, 1);
        directed_rows.push_back(row);
        row.item = make_item(CMD_ACK, 0, 0, 0, 1, 1, 16'hFFFF, 0, 0);
        row.typed = make_result(KIND_STATUS, 1, 0, 0, 0, 0, 0, 0);
        directed_rows.push_back(row);
        row.has_typed = 0;
        row.item = make_item(CMD_PUSH, 24'hFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
        directed_rows.push_back(row);
        // An ack beyond the sent data, then a partial ack, then a regression.
        row.item = make_item(CMD_ACK, 0, 0, 0, 32'd40000, 1, 16'hFFFF, 0, 0);
        directed_rows.push_back(row);
        row.item = make_item(CMD_ACK, 0, 0, 0, 32'd1001, 1, 16'hFFFF, 0, 0);
        directed_rows.push_back(row);
        row.item = make_item(CMD_ACK, 0, 0, 0, 32'd1, 1, 16'hFFFF, 0, 0);
        directed_rows.push_back(row);
        // Window update without an ackno, then expiries with a zero window.
        row.item = make_item(CMD_ACK, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
        directed_rows.push_back(row);
        row.item = make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        directed_rows.push_back(row);
        row.item = make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        directed_rows.push_back(row);
        row.item = make_item(CMD_PUSH, 24'd7, 0, 0, 0, 0, 0, 0, 0);
        directed_rows.push_back(row);
        row.ack_to_next = 1;
        row.item = make_item(CMD_ACK, 0, 0, 0, 0, 1, 16'd100, 0, 0);
        directed_rows.push_back(row);
        row.ack_to_next = 0;
        row.item = make_item(CMD_PUSH, 24'd10, 1, 1, 0, 0, 0, 0, 0);
        directed_rows.push_back(row);
        row.item = make_item(CMD_PUSH, 24'd5, 1, 0, 0, 0, 0, 0, 0);
        directed_rows.push_back(row);
        row.ack_to_next = 1;
        row.item = make_item(CMD_ACK, 0, 0, 0, 0, 1, 16'hFFFF, 0, 0);
        directed_rows.push_back(row);
        row.ack_to_next = 0;
        row.item = make_item(CMD_PUSH, 24'd0, 0, 0, 0, 0, 0, 0, 0);
        directed_rows.push_back(row);
        row.item = make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
        directed_rows.push_back(row);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.ack_to_next)
                row.item.ackno = wrap_abs(next_seq);
            send_request(row.item, row.has_typed, row.typed);
        end

        for (int phase = 0; phase < 4; phase++) begin
            if (phase > 0) begin
                @(negedge i_clk);
                req_if.valid = 1'b0;
                wait_idle();
                case (phase)
                    1: begin
                        write_reg(REG_ISN, 32'hFFFF_FFF0);
                        write_reg(REG_IRTO, 32'd1);
                        write_reg(REG_MAXP, 32'd1);
                    end
                    2: begin
                        write_reg(REG_ISN, $urandom);
                        write_reg(REG_IRTO, 32'd1000000);
                        write_reg(REG_MAXP, 32'd1000);
                    end
                    default: begin
                        write_reg(REG_ISN, $urandom);
                        write_reg(REG_IRTO, $urandom_range(1, 5000));
                        write_reg(REG_MAXP, $urandom_range(1, 1000));
                    end
                endcase
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                no_idle = (n >= 60 && n < 80);
                if (phase == 1 && n == 40)
                    hold_request = 1;
                if (phase == 2 && n == 50) begin
                    // Let everything drain before going on.
                    @(negedge i_clk);
                    req_if.valid = 1'b0;
                    wait (pending_results.size() == 0);
                end
                send_request(random_request(phase == 3 && n >= RANDOM_PER_PHASE - 6), 0, none);
            end
        end
        no_idle = 0;

        @(negedge i_clk);
        req_if.valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        drain_guard = pending_results.size();
        if (mismatches == 0 && drain_guard == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
